>>> sv/i2cmts_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// No dependencies; the top level and its checker import this package.
`timescale 1ns / 1ps

package i2cmts_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_CONT   = 2'd2,
    OP_STATUS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_START  = 2'd1,
    PH_ACTIVE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    OUTC_BUSY   = 2'd0,
    OUTC_DONE   = 2'd1,
    OUTC_FAILED = 2'd2
  } outcome_e;

  // Two-wire master status codes
  localparam logic [7:0] ST_REP_START     = 8'h10;
  localparam logic [7:0] ST_MTX_ADR_ACK   = 8'h18;
  localparam logic [7:0] ST_MTX_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MRX_ADR_ACK   = 8'h40;
  localparam logic [7:0] ST_MRX_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MRX_DATA_NACK = 8'h58;

  localparam logic [7:0] NO_FAIL = 8'd248;

  // End option bits
  localparam int OPT_STOP_BIT = 0;
  localparam int OPT_REP_BIT  = 1;

  typedef struct packed {
    op_e        operation;
    logic [5:0] buffer_index;
    logic [7:0] data_byte;
    logic [7:0] address_byte;
    logic [6:0] byte_count;
    logic       send_stop;
    logic       send_rep_start;
    logic [7:0] status_code;
  } in_t;

  typedef struct packed {
    logic       ctl_valid;
    logic       ctl_int_enable;
    logic       ctl_clear_flag;
    logic       ctl_ack;
    logic       ctl_start;
    logic       ctl_stop;
    logic       tx_valid;
    logic       rx_valid;
    logic [7:0] byte_value;
    logic [5:0] rx_index;
    outcome_e   outcome;
    logic [7:0] fail_code;
  } out_t;

  // Control word plus a flag telling that the transfer ended here
  typedef struct packed {
    logic valid;
    logic ie;
    logic clr;
    logic ack;
    logic sta;
    logic sto;
    logic done;
  } ctl_t;

  function automatic ctl_t ctl_word(logic ie, logic clr, logic ack, logic sta, logic sto);
    ctl_t c;
    c.valid = 1'b1;
    c.ie    = ie;
    c.clr   = clr;
    c.ack   = ack;
    c.sta   = sta;
    c.sto   = sto;
    c.done  = 1'b0;
    return c;
  endfunction

  function automatic ctl_t finish_ctl(logic [1:0] opt);
    ctl_t c;
    if (opt[OPT_STOP_BIT]) begin
      c = ctl_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    end else if (opt[OPT_REP_BIT]) begin
      c = ctl_word(1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    end else begin
      c = ctl_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    end
    c.done = 1'b1;
    return c;
  endfunction

  // Control word for the next receive: NACK on the last byte when an end option is set
  function automatic ctl_t recv_ctl(logic [6:0] pos, logic [6:0] len, logic [1:0] opt);
    ctl_t c;
    if (pos >= len) begin
      c = finish_ctl(opt);
    end else if ({1'b0, len} == ({1'b0, pos} + 8'd1) && opt != 2'b00) begin
      c = ctl_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    end else begin
      c = ctl_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    end
    return c;
  endfunction

endpackage

>>> sv/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer: top level with the transmit/receive buffer RAM.
// Depends on i2cmts_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one operation per beat:
//   buffer load, begin transfer, continue transfer or a bus status event from
//   the byte engine. Output channel (out_valid / out_stall / out_item) returns
//   exactly one result beat per input beat, in order: the control word for the
//   engine, a byte to send or a received byte with its buffer index, the
//   outcome and the last recorded fail code.
//   From acceptance to out_valid a beat passes through the read stage (the
//   synchronous buffer read) and then the output register. Throughput is one
//   beat per cycle while the receiver does not stall; the small sequencing
//   registers update at acceptance, so a following beat sees them at once,
//   and buffer writes land before the next read is issued.
//   Reset clears the sequencing state (phase idle, fail code 248) and empties
//   the pipeline; buffer contents are undefined until loaded.
//   When the receiver stalls, the output register holds its beat, one more
//   beat can sit in the read stage, and in_stall rises once both are full.
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
#(
  parameter int BUF_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [AW-1:0] SLOT_LAST = AW'(BUF_DEPTH - 1);

  typedef logic [AW-1:0] slot_lut_t [64];

  function automatic slot_lut_t build_slot_lut();
    slot_lut_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = AW'(i % BUF_DEPTH);
    end
    return t;
  endfunction

  localparam slot_lut_t SLOT_LUT = build_slot_lut();

  // Sequencing registers
  phase_e     phase, phase_next;
  logic [6:0] byte_position, byte_position_next;
  logic [AW-1:0] slot_pos, slot_pos_next;
  logic [6:0] transfer_length, transfer_length_next;
  logic [1:0] end_option, end_option_next;
  logic [7:0] saved_address, saved_address_next;
  logic [7:0] last_fail_code, last_fail_code_next;

  // Buffer RAM
  logic [7:0]    mem [BUF_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Read stage
  logic     s1_valid;
  out_t     s1_res, s1_res_next;
  out_t     s1_out;
  logic     s1_from_mem, s1_from_mem_next;
  logic     s1_adv;
  logic     in_acc;

  logic     st_tx_ack, st_rx_adr, st_rx_data, st_rx_nack;
  logic [6:0]    pos_inc;
  logic [AW-1:0] slot_inc;
  logic [1:0]    opt_in;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign st_tx_ack  = (in_item.status_code == ST_MTX_ADR_ACK) ||
                      (in_item.status_code == ST_MTX_DATA_ACK);
  assign st_rx_adr  = (in_item.status_code == ST_MRX_ADR_ACK);
  assign st_rx_data = (in_item.status_code == ST_MRX_DATA_ACK);
  assign st_rx_nack = (in_item.status_code == ST_MRX_DATA_NACK);
  assign opt_in     = {in_item.send_rep_start, in_item.send_stop};

  // Position and buffer slot advance together; slot wraps at the buffer depth
  assign pos_inc  = byte_position + 7'd1;
  assign slot_inc = (byte_position == 7'd127 || slot_pos == SLOT_LAST) ? '0
                                                                      : slot_pos + AW'(1);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (in_acc) begin
      unique case (in_item.operation)
        OP_LOAD: begin
          phase_next = phase;
        end
        OP_BEGIN: begin
          phase_next = (in_item.status_code != ST_REP_START) ? PH_START : PH_ACTIVE;
        end
        OP_CONT: begin
          if (in_item.byte_count == 7'd0) begin
            phase_next = PH_IDLE;
          end else if (st_tx_ack || st_rx_adr || st_rx_data) begin
            phase_next = PH_ACTIVE;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        OP_STATUS: begin
          unique case (phase)
            PH_START: phase_next = PH_ACTIVE;
            PH_ACTIVE: begin
              priority if (st_tx_ack) begin
                phase_next = (byte_position < transfer_length) ? PH_ACTIVE : PH_IDLE;
              end else if (st_rx_data) begin
                phase_next = (pos_inc >= transfer_length) ? PH_IDLE : PH_ACTIVE;
              end else if (st_rx_adr) begin
                phase_next = (byte_position >= transfer_length) ? PH_IDLE : PH_ACTIVE;
              end else begin
                phase_next = PH_IDLE;
              end
            end
            default: phase_next = phase;
          endcase
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Result and datapath
  always_comb begin
    ctl_t c;
    c                    = '0;
    s1_res_next          = '0;
    s1_res_next.outcome  = OUTC_BUSY;
    s1_from_mem_next     = 1'b0;
    byte_position_next   = byte_position;
    slot_pos_next        = slot_pos;
    transfer_length_next = transfer_length;
    end_option_next      = end_option;
    saved_address_next   = saved_address;
    last_fail_code_next  = last_fail_code;
    wr_en                = 1'b0;
    wr_addr              = slot_pos;
    wr_data              = in_item.data_byte;
    rd_addr              = slot_pos;

    unique case (in_item.operation)
      OP_LOAD: begin
        wr_en   = in_acc;
        wr_addr = SLOT_LUT[in_item.buffer_index];
      end
      OP_BEGIN: begin
        transfer_length_next = in_item.byte_count;
        end_option_next      = opt_in;
        byte_position_next   = 7'd0;
        slot_pos_next        = '0;
        saved_address_next   = in_item.address_byte;
        if (in_item.status_code != ST_REP_START) begin
          c = ctl_word(1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        end else begin
          c = ctl_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
          s1_res_next.tx_valid   = 1'b1;
          s1_res_next.byte_value = in_item.address_byte;
        end
      end
      OP_CONT: begin
        transfer_length_next = in_item.byte_count;
        end_option_next      = opt_in;
        byte_position_next   = 7'd0;
        slot_pos_next        = '0;
        rd_addr              = '0;
        if (in_item.byte_count == 7'd0) begin
          s1_res_next.outcome = OUTC_DONE;
        end else if (st_tx_ack) begin
          c = ctl_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
          s1_res_next.tx_valid = 1'b1;
          s1_from_mem_next     = 1'b1;
          byte_position_next   = 7'd1;
          slot_pos_next        = (BUF_DEPTH > 1) ? AW'(1) : '0;
        end else if (st_rx_adr || st_rx_data) begin
          c = recv_ctl(7'd0, in_item.byte_count, opt_in);
        end else begin
          last_fail_code_next = in_item.status_code;
          s1_res_next.outcome = OUTC_FAILED;
        end
      end
      OP_STATUS: begin
        unique case (phase)
          PH_START: begin
            c = ctl_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            s1_res_next.tx_valid   = 1'b1;
            s1_res_next.byte_value = saved_address;
          end
          PH_ACTIVE: begin
            priority if (st_tx_ack) begin
              if (byte_position < transfer_length) begin
                c = ctl_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
                s1_res_next.tx_valid = 1'b1;
                s1_from_mem_next     = 1'b1;
                byte_position_next   = pos_inc;
                slot_pos_next        = slot_inc;
              end else begin
                c = finish_ctl(end_option);
              end
            end else if (st_rx_data || st_rx_nack) begin
              wr_en                  = in_acc;
              s1_res_next.rx_valid   = 1'b1;
              s1_res_next.byte_value = in_item.data_byte;
              s1_res_next.rx_index   = 6'(slot_pos);
              byte_position_next     = pos_inc;
              slot_pos_next          = slot_inc;
              c = st_rx_nack ? finish_ctl(end_option)
                             : recv_ctl(pos_inc, transfer_length, end_option);
            end else if (st_rx_adr) begin
              c = recv_ctl(byte_position, transfer_length, end_option);
            end else begin
              last_fail_code_next = in_item.status_code;
              c = ctl_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
              s1_res_next.outcome = OUTC_FAILED;
            end
          end
          default: begin
            c = '0;
          end
        endcase
      end
      default: begin
        c = '0;
      end
    endcase

    s1_res_next.ctl_valid      = c.valid;
    s1_res_next.ctl_int_enable = c.ie;
    s1_res_next.ctl_clear_flag = c.clr;
    s1_res_next.ctl_ack        = c.ack;
    s1_res_next.ctl_start      = c.sta;
    s1_res_next.ctl_stop       = c.sto;
    if (c.done) begin
      s1_res_next.outcome = OUTC_DONE;
    end
    s1_res_next.fail_code = last_fail_code_next;
  end

  // Sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_position   <= 7'd0;
      slot_pos        <= '0;
      transfer_length <= 7'd0;
      end_option      <= 2'd0;
      saved_address   <= 8'd0;
      last_fail_code  <= NO_FAIL;
    end else if (in_acc) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      slot_pos        <= slot_pos_next;
      transfer_length <= transfer_length_next;
      end_option      <= end_option_next;
      saved_address   <= saved_address_next;
      last_fail_code  <= last_fail_code_next;
    end
  end

  // Buffer RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Merge the buffer byte into the read-stage beat
  always_comb begin
    s1_out = s1_res;
    if (s1_from_mem) begin
      s1_out.byte_value = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res      <= s1_res_next;
      s1_from_mem <= s1_from_mem_next;
    end
    if (s1_valid && s1_adv) begin
      out_item <= s1_out;
    end
  end

endmodule

>>> sv/i2cmts_checker.sv
// Port-level checker for the I2C master transfer sequencer, bound to the top level.
// Depends on i2cmts_pkg.
`timescale 1ns / 1ps

module i2cmts_checker
  import i2cmts_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input out_t out_item
);

  // A result beat never carries both a send byte and a received byte
  a_tx_rx_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.tx_valid && out_item.rx_valid))
    else $error("tx_valid and rx_valid both set");

  // Idle fields of a result beat read as zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_item.ctl_valid ||
       !(out_item.ctl_int_enable || out_item.ctl_clear_flag || out_item.ctl_ack ||
         out_item.ctl_start || out_item.ctl_stop)) &&
      (out_item.tx_valid || out_item.rx_valid || out_item.byte_value == 8'd0) &&
      (out_item.rx_valid || out_item.rx_index == 6'd0))
    else $error("unused result field not zero");

  // A failure that issues a control word always forces stop
  a_fail_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.outcome == OUTC_FAILED && out_item.ctl_valid |->
      out_item.ctl_stop && !out_item.ctl_start)
    else $error("failure without stop");

  // Fail code changes only on a failure beat
  a_fail_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid && !out_stall) && out_item.outcome != OUTC_FAILED |->
      out_item.fail_code == $past(out_item.fail_code))
    else $error("fail code changed without failure");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_i2cmts_checker (.*);

>>> bench/testbench.sv
// Self-checking bench for i2c_master_transfer_sequencer: directed transfers, then random traffic.
// Holds its own model of the sequencer in a scoreboard class; needs i2cmts_pkg and the top level.
`timescale 1ns / 1ps

import i2cmts_pkg::*;

class xfer_scoreboard;
  logic [7:0] buf_mem [64];
  bit         loaded [64];
  logic [6:0] pos;
  logic [6:0] len;
  logic [1:0] opt;
  phase_e     ph;
  logic [7:0] addr;
  logic [7:0] fail;
  out_t       res;
  out_t       pending [$];
  int         errors;

  function new();
    pos = '0;
    len = '0;
    opt = '0;
    ph = PH_IDLE;
    addr = '0;
    fail = NO_FAIL;
    errors = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;
  endfunction

  function void ctl(bit ie, bit clr, bit ack, bit sta, bit sto);
    res.ctl_valid = 1'b1;
    res.ctl_int_enable = ie;
    res.ctl_clear_flag = clr;
    res.ctl_ack = ack;
    res.ctl_start = sta;
    res.ctl_stop = sto;
  endfunction

  function void tx_byte(logic [7:0] v);
    res.tx_valid = 1'b1;
    res.byte_value = v;
  endfunction

  function void end_xfer();
    if (opt[OPT_STOP_BIT]) ctl(0, 1, 0, 0, 1);
    else if (opt[OPT_REP_BIT]) ctl(0, 1, 0, 1, 0);
    else ctl(0, 0, 0, 0, 0);
    res.outcome = OUTC_DONE;
    ph = PH_IDLE;
  endfunction

  // NACK the last byte only when the transfer ends with stop or repeated start
  function void rx_next();
    if (pos >= len) end_xfer();
    else if (len - pos == 7'd1 && opt != 2'b00) ctl(1, 1, 0, 0, 0);
    else ctl(1, 1, 1, 0, 0);
  endfunction

  function void rx_store(logic [7:0] v);
    buf_mem[pos[5:0]] = v;
    loaded[pos[5:0]] = 1'b1;
    res.rx_valid = 1'b1;
    res.byte_value = v;
    res.rx_index = pos[5:0];
    pos = pos + 7'd1;
  endfunction

  static function bit is_tx_ack(logic [7:0] st);
    return st == ST_MTX_ADR_ACK || st == ST_MTX_DATA_ACK;
  endfunction

  // True when the beat would send a buffer slot that was never written
  function bit reads_unloaded(in_t it, output logic [5:0] s);
    s = '0;
    if (it.operation == OP_CONT && it.byte_count != 0 && is_tx_ack(it.status_code))
      return !loaded[0];
    if (it.operation == OP_STATUS && ph == PH_ACTIVE && is_tx_ack(it.status_code) && pos < len) begin
      s = pos[5:0];
      return !loaded[s];
    end
    return 1'b0;
  endfunction

  function void note(in_t it);
    logic [7:0] st;
    st = it.status_code;
    res = '0;
    case (it.operation)
      OP_LOAD: begin
        buf_mem[it.buffer_index] = it.data_byte;
        loaded[it.buffer_index] = 1'b1;
      end
      OP_BEGIN: begin
        len = it.byte_count;
        opt = {it.send_rep_start, it.send_stop};
        pos = '0;
        addr = it.address_byte;
        if (st != ST_REP_START) begin
          ctl(0, 1, 0, 1, 0);
          ph = PH_START;
        end else begin
          tx_byte(addr);
          ctl(1, 1, 0, 0, 0);
          ph = PH_ACTIVE;
        end
      end
      OP_CONT: begin
        len = it.byte_count;
        opt = {it.send_rep_start, it.send_stop};
        pos = '0;
        if (it.byte_count == 0) begin
          res.outcome = OUTC_DONE;
          ph = PH_IDLE;
        end else if (is_tx_ack(st)) begin
          tx_byte(buf_mem[0]);
          pos = 7'd1;
          ctl(1, 1, 0, 0, 0);
          ph = PH_ACTIVE;
        end else if (st == ST_MRX_ADR_ACK || st == ST_MRX_DATA_ACK) begin
          rx_next();
          ph = PH_ACTIVE;
        end else begin
          fail = st;
          res.outcome = OUTC_FAILED;
          ph = PH_IDLE;
        end
      end
      default: begin
        if (ph == PH_START) begin
          tx_byte(addr);
          ctl(1, 1, 0, 0, 0);
          ph = PH_ACTIVE;
        end else if (ph == PH_ACTIVE) begin
          if (is_tx_ack(st)) begin
            if (pos < len) begin
              tx_byte(buf_mem[pos[5:0]]);
              pos = pos + 7'd1;
              ctl(1, 1, 0, 0, 0);
            end else begin
              end_xfer();
            end
          end else if (st == ST_MRX_DATA_ACK) begin
            rx_store(it.data_byte);
            rx_next();
          end else if (st == ST_MRX_ADR_ACK) begin
            rx_next();
          end else if (st == ST_MRX_DATA_NACK) begin
            rx_store(it.data_byte);
            end_xfer();
          end else begin
            // unexpected status: record it and force a stop
            fail = st;
            ctl(0, 1, 0, 0, 1);
            res.outcome = OUTC_FAILED;
            ph = PH_IDLE;
          end
        end
      end
    endcase
    res.fail_code = fail;
    pending.push_back(res);
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task cmp(string f, logic [7:0] g, logic [7:0] w);
    if (g !== w) report($sformatf("%s got %0h, want %0h", f, g, w));
  endtask

  task check(out_t got);
    out_t want;
    if (pending.size() == 0) begin
      report("result beat with nothing pending");
      return;
    end
    want = pending.pop_front();
    cmp("ctl_valid", got.ctl_valid, want.ctl_valid);
    cmp("ctl_int_enable", got.ctl_int_enable, want.ctl_int_enable);
    cmp("ctl_clear_flag", got.ctl_clear_flag, want.ctl_clear_flag);
    cmp("ctl_ack", got.ctl_ack, want.ctl_ack);
    cmp("ctl_start", got.ctl_start, want.ctl_start);
    cmp("ctl_stop", got.ctl_stop, want.ctl_stop);
    cmp("tx_valid", got.tx_valid, want.tx_valid);
    cmp("rx_valid", got.rx_valid, want.rx_valid);
    cmp("byte_value", got.byte_value, want.byte_value);
    cmp("rx_index", got.rx_index, want.rx_index);
    cmp("outcome", got.outcome, want.outcome);
    cmp("fail_code", got.fail_code, want.fail_code);
  endtask
endclass

module testbench;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;

  // status codes the sequencer treats as unexpected
  localparam logic [7:0] ST_BUS_ERROR     = 8'h00;
  localparam logic [7:0] ST_START         = 8'h08;
  localparam logic [7:0] ST_MTX_ADR_NACK  = 8'h20;
  localparam logic [7:0] ST_MTX_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST      = 8'h38;
  localparam logic [7:0] ST_NO_INFO       = 8'hF8;

  localparam logic [1:0] OPT_NONE = 2'b00;
  localparam logic [1:0] OPT_STOP = 2'b01;
  localparam logic [1:0] OPT_REP  = 2'b10;
  localparam logic [1:0] OPT_BOTH = 2'b11;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  xfer_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;
  bit rd_dir = 1'b0;

  i2c_master_transfer_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
    if (!rst && out_valid && !out_stall) sb.check(out_item);
  end

  function automatic in_t mk(op_e op, logic [7:0] st, logic [6:0] cnt = 0,
                             logic [1:0] o = 0, logic [7:0] adr = 0,
                             logic [7:0] dat = 0, logic [5:0] idx = 0);
    in_t it;
    it = '0;
    it.operation = op;
    it.status_code = st;
    it.byte_count = cnt;
    it.send_stop = o[OPT_STOP_BIT];
    it.send_rep_start = o[OPT_REP_BIT];
    it.address_byte = adr;
    it.data_byte = dat;
    it.buffer_index = idx;
    return it;
  endfunction

  function automatic in_t rand_bits();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(in_t)-1:0];
  endfunction

  // mostly short transfers, a few up to the full count field
  function automatic logic [6:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 7'($urandom_range(8));
    if (r < 95) return 7'($urandom_range(64, 9));
    return 7'($urandom_range(127, 65));
  endfunction

  function automatic in_t as_begin(in_t it);
    it.operation = OP_BEGIN;
    it.byte_count = rand_count();
    rd_dir = it.address_byte[0];
    if ($urandom_range(4) == 0) it.status_code = ST_REP_START;
    return it;
  endfunction

  function automatic in_t as_cont(in_t it);
    int r;
    r = $urandom_range(99);
    it.operation = OP_CONT;
    it.byte_count = rand_count();
    if (r < 40) begin
      it.status_code = (r < 20) ? ST_MTX_ADR_ACK : ST_MTX_DATA_ACK;
      rd_dir = 1'b0;
    end else if (r < 80) begin
      it.status_code = (r < 60) ? ST_MRX_ADR_ACK : ST_MRX_DATA_ACK;
      rd_dir = 1'b1;
    end
    return it;
  endfunction

  function automatic logic [7:0] bus_status();
    int r;
    r = $urandom_range(99);
    if (rd_dir) begin
      if (r < 70) return ST_MRX_DATA_ACK;
      if (r < 85) return ST_MRX_DATA_NACK;
      return ST_MRX_ADR_ACK;
    end
    return (r < 85) ? ST_MTX_DATA_ACK : ST_MTX_ADR_ACK;
  endfunction

  function automatic in_t noise(in_t it, int r);
    if (r < 50) it.operation = OP_LOAD;
    else if (r < 80) it = as_begin(it);
    else it = as_cont(it);
    return it;
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int r;
    it = rand_bits();
    r = $urandom_range(99);
    case (sb.ph)
      PH_ACTIVE: begin
        it.operation = OP_STATUS;
        if (r < 85) it.status_code = bus_status();
        else if (r >= 90) it = noise(it, $urandom_range(99));
      end
      PH_START: begin
        it.operation = OP_STATUS;
        if (r >= 85) it = noise(it, $urandom_range(99));
      end
      default: begin
        if (r < 55) it = as_begin(it);
        else if (r < 70) it = as_cont(it);
        else if (r < 85) it.operation = OP_LOAD;
        else it.operation = OP_STATUS;
      end
    endcase
    return it;
  endfunction

  task automatic put_beat(in_t it);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  // slots are loaded on demand so nothing unwritten is ever sent
  task automatic put_item(in_t it);
    logic [5:0] s;
    in_t ld;
    if (sb.reads_unloaded(it, s)) begin
      ld = rand_bits();
      ld.operation = OP_LOAD;
      ld.buffer_index = s;
      put_beat(ld);
    end
    put_beat(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int n;
    int stage;
    int last_stage;
    in_t it;
    send_idle = 25;
    recv_idle = 71;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    put_item(mk(OP_LOAD, ST_NO_INFO, 0, OPT_NONE, 0, 8'h00, 6'd0));
    put_item(mk(OP_LOAD, ST_NO_INFO, 0, OPT_NONE, 0, 8'hFF, 6'd1));
    put_item(mk(OP_LOAD, ST_NO_INFO, 0, OPT_NONE, 0, 8'hA5, 6'd63));
    put_item(mk(OP_STATUS, ST_MTX_DATA_ACK));                 // idle: ignored
    put_item(mk(OP_BEGIN, ST_NO_INFO, 7'd2, OPT_STOP, 8'hFE));
    put_item(mk(OP_STATUS, ST_BUS_ERROR));                    // any code sends the address
    put_item(mk(OP_STATUS, ST_MTX_ADR_ACK));
    put_item(mk(OP_STATUS, ST_MTX_DATA_ACK));
    put_item(mk(OP_STATUS, ST_MTX_DATA_ACK));                 // ends with stop
    put_item(mk(OP_BEGIN, ST_REP_START, 7'd2, OPT_REP, 8'h01));
    put_item(mk(OP_STATUS, ST_MRX_ADR_ACK));
    put_item(mk(OP_STATUS, ST_MRX_DATA_ACK, 0, OPT_NONE, 0, 8'hFF));
    put_item(mk(OP_STATUS, ST_MRX_DATA_NACK, 0, OPT_NONE, 0, 8'h00));
    put_item(mk(OP_CONT, ST_MTX_DATA_ACK, 7'd0, OPT_BOTH));   // zero bytes: done at once
    put_item(mk(OP_CONT, ST_MTX_DATA_ACK, 7'd1, OPT_NONE));
    put_item(mk(OP_STATUS, ST_MTX_DATA_ACK));                 // no end option: empty ctl word
    put_item(mk(OP_CONT, ST_MRX_DATA_ACK, 7'd1, OPT_BOTH));
    put_item(mk(OP_STATUS, ST_MRX_DATA_ACK, 0, OPT_NONE, 0, 8'h3C)); // last byte, received with ACK
    put_item(mk(OP_CONT, ST_MTX_DATA_NACK, 7'd5, OPT_STOP));  // continue fails
    put_item(mk(OP_BEGIN, ST_START, 7'd127, OPT_NONE, 8'hFF));
    put_item(mk(OP_BEGIN, ST_REP_START, 7'd64, OPT_STOP, 8'h00)); // replaces running one
    put_item(mk(OP_STATUS, ST_ARB_LOST));
    put_item(mk(OP_CONT, ST_MRX_ADR_ACK, 7'd3, OPT_NONE));
    put_item(mk(OP_STATUS, ST_MRX_DATA_ACK, 0, OPT_NONE, 0, 8'h81));
    put_item(mk(OP_STATUS, ST_MTX_ADR_NACK));
    drain();

    n = 0;
    last_stage = 0;
    while (n < RANDOM_ITEMS) begin
      stage = n * 3 / RANDOM_ITEMS;
      if (stage != last_stage) begin
        // hold the sender until the pipeline is empty before changing the mix
        drain();
        last_stage = stage;
        send_idle = (stage == 1) ? 71 : 0;
        recv_idle = (stage == 1) ? 25 : 0;
      end
      it = rand_item();
      if (!(it.operation == OP_STATUS && sb.ph == PH_IDLE)) n++;
      put_item(it);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("results still pending at end of run");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
